FILE: sv/cnis_pkg.sv
`timescale 1ns / 1ps

package cnis_pkg;

    // default widths of the depth and counter words
    localparam int DEPTH_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF = 16;

    // configuration port index width
    localparam int CFG_INDEX_WIDTH = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SMAX_DEPTH       = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REGEN_STEP_DEPTH = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EVENT_GAP_STEPS  = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_PONDED_DEPTH = CFG_INDEX_WIDTH'(3);

    // register reset values
    localparam longint SMAX_RESET      = 64'd3495253;
    localparam longint REGEN_RESET     = 64'd347;
    localparam longint GAP_RESET       = 64'd605;
    localparam longint MIN_PONDED_RESET = 64'd168;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // latch the input beat
        logic prep;      // event bookkeeping and rain accumulation
        logic mul_lo;    // low partial product and divisor
        logic mul_hi;    // high partial product, divider load
        logic div_step;  // one quotient bit
        logic calc;      // step infiltration
        logic commit;    // state update and output load
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic rain_nz;   // latched rain depth is nonzero
        logic div_last;  // final quotient bit this cycle
    } t_status;

endpackage

FILE: sv/cnis_ctrl.sv
`timescale 1ns / 1ps

module cnis_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_cfg_ready,
    input  cnis_pkg::t_status i_status,
    output cnis_pkg::t_cmd    o_cmd
);
    import cnis_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PREP   = 7'b0000010,
        S_MUL_LO = 7'b0000100,
        S_MUL_HI = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_CALC   = 7'b0100000,
        S_COMMIT = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_out_free;

    // output slot is free when empty or being taken this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = i_status.rain_nz ? S_MUL_LO : S_CALC;
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = w_out_free;
                if (w_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: sv/cnis_dp.sv
`timescale 1ns / 1ps

module cnis_dp #(
    parameter int DEPTH_WIDTH = cnis_pkg::DEPTH_WIDTH_DEF,
    parameter int COUNT_WIDTH = cnis_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cnis_pkg::t_cmd                      i_cmd,
    output cnis_pkg::t_status                   o_status,
    input  logic [DEPTH_WIDTH-1:0]              i_rain_depth,
    input  logic [DEPTH_WIDTH-1:0]              i_ponded_depth,
    input  logic                                i_cfg_we,
    input  logic [cnis_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [DEPTH_WIDTH-1:0]              i_cfg_data,
    output logic [DEPTH_WIDTH-1:0]              o_infil_depth,
    output logic [DEPTH_WIDTH-1:0]              o_capacity_left
);
    import cnis_pkg::*;

    localparam int D       = DEPTH_WIDTH;
    localparam int HALF    = (D + 1) / 2;
    localparam int HI      = D - HALF;
    localparam int CNT_W   = $clog2(D);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(D - 1);
    localparam logic [D-1:0]     DEPTH_MAX = {D{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] DRY_MAX = {COUNT_WIDTH{1'b1}};

    // configuration registers
    logic [D-1:0]           r_smax, r_regen, r_minp;
    logic [COUNT_WIDTH-1:0] r_gap;

    // model state
    logic [D-1:0]           r_cap, r_er, r_ei, r_ec, r_li;
    logic [COUNT_WIDTH-1:0] r_dry;

    // working registers
    logic [D-1:0]     r_rain, r_ponded;
    logic [2*D-1:0]   r_prod;
    logic [D:0]       r_sum;
    logic [D:0]       r_rem;
    logic [D-1:0]     r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [D-1:0]     r_f1;
    logic             r_dry_inc;
    logic [D-1:0]     r_out_infil, r_out_cap;

    // prep step
    logic           w_new_event;
    logic [D-1:0]   w_er_base;
    logic [D:0]     w_er_sum;
    logic [D-1:0]   n_er;

    always_comb begin
        w_new_event = (r_dry >= r_gap);
        w_er_base   = w_new_event ? '0 : r_er;
        w_er_sum    = {1'b0, w_er_base} + {1'b0, r_rain};
        n_er        = w_er_sum[D] ? DEPTH_MAX : w_er_sum[D-1:0];
    end

    // partial products of event rain by event capacity
    logic [D+HALF-1:0] w_pp_lo;
    logic [D+HI-1:0]   w_pp_hi;
    logic [2*D-1:0]    w_prod;

    assign w_pp_lo = {{HALF{1'b0}}, r_er} * {{D{1'b0}}, r_ec[HALF-1:0]};
    assign w_pp_hi = {{HI{1'b0}}, r_er} * {{D{1'b0}}, r_ec[D-1:HALF]};
    assign w_prod  = r_prod + {w_pp_hi, {HALF{1'b0}}};

    // restoring divider step
    logic [D+1:0] w_trial;
    logic [D+1:0] w_diff;
    logic         w_qbit;

    assign w_trial = {r_rem, r_quo[D-1]};
    assign w_diff  = w_trial - {1'b0, r_sum};
    assign w_qbit  = (w_trial >= {1'b0, r_sum});

    // step infiltration before the state update
    logic [D-1:0] w_target;
    logic [D-1:0] n_f1;
    logic         n_dry_inc;
    logic [D:0]   w_avail;

    always_comb begin
        w_target  = (r_sum == '0) ? '0 : r_quo;
        n_f1      = '0;
        n_dry_inc = 1'b0;
        w_avail   = {1'b0, r_rain} + {1'b0, r_ponded};
        priority if (r_rain != '0) begin
            if (w_target > r_ei && r_cap != '0) n_f1 = w_target - r_ei;
        end else if (r_ponded > r_minp && r_cap != '0) begin
            n_f1 = (r_li < r_cap) ? r_li : r_cap;
        end else begin
            n_dry_inc = (r_dry != DRY_MAX);
        end
        if ({1'b0, n_f1} > w_avail) n_f1 = w_avail[D-1:0];
    end

    // state update at commit
    logic [D:0]   w_ei_sum, w_regen_sum;
    logic [D-1:0] n_ei, n_cap;

    always_comb begin
        w_ei_sum    = {1'b0, r_ei} + {1'b0, r_f1};
        w_regen_sum = {1'b0, r_cap} + {1'b0, r_regen};
        if (r_f1 != '0) begin
            n_ei  = w_ei_sum[D] ? DEPTH_MAX : w_ei_sum[D-1:0];
            n_cap = (r_cap > r_f1) ? (r_cap - r_f1) : '0;
        end else begin
            n_ei  = r_ei;
            n_cap = (w_regen_sum > {1'b0, r_smax}) ? r_smax : w_regen_sum[D-1:0];
        end
    end

    // configuration and model state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smax  <= D'(SMAX_RESET);
            r_regen <= D'(REGEN_RESET);
            r_gap   <= COUNT_WIDTH'(GAP_RESET);
            r_minp  <= D'(MIN_PONDED_RESET);
            r_cap   <= D'(SMAX_RESET);
            r_er    <= '0;
            r_ei    <= '0;
            r_dry   <= '0;
            r_ec    <= D'(SMAX_RESET);
            r_li    <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SMAX_DEPTH: begin
                        r_smax <= i_cfg_data;
                        r_cap  <= i_cfg_data;
                        r_er   <= '0;
                        r_ei   <= '0;
                        r_dry  <= '0;
                        r_ec   <= i_cfg_data;
                        r_li   <= '0;
                    end
                    CFG_REGEN_STEP_DEPTH: r_regen <= i_cfg_data;
                    CFG_EVENT_GAP_STEPS:  r_gap   <= i_cfg_data[COUNT_WIDTH-1:0];
                    CFG_MIN_PONDED_DEPTH: r_minp  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // event opening and rain accumulation
            if (i_cmd.prep && r_rain != '0) begin
                r_er  <= n_er;
                r_dry <= '0;
                if (w_new_event) begin
                    r_ei <= '0;
                    r_li <= '0;
                    r_ec <= r_cap;
                end
            end
            // divider bit counter
            if (i_cmd.mul_hi) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            // end of step
            if (i_cmd.commit) begin
                r_ei  <= n_ei;
                r_cap <= n_cap;
                r_li  <= r_f1;
                if (r_dry_inc) r_dry <= r_dry + COUNT_WIDTH'(1);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rain   <= i_rain_depth;
            r_ponded <= i_ponded_depth;
        end
        if (i_cmd.mul_lo) begin
            r_prod <= {{HI{1'b0}}, w_pp_lo};
            r_sum  <= {1'b0, r_er} + {1'b0, r_ec};
        end
        if (i_cmd.mul_hi) begin
            r_rem <= {1'b0, w_prod[2*D-1:D]};
            r_quo <= w_prod[D-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? w_diff[D:0] : w_trial[D:0];
            r_quo <= {r_quo[D-2:0], w_qbit};
        end
        if (i_cmd.calc) begin
            r_f1      <= n_f1;
            r_dry_inc <= n_dry_inc;
        end
        if (i_cmd.commit) begin
            r_out_infil <= r_f1;
            r_out_cap   <= n_cap;
        end
    end

    assign o_status.rain_nz  = (r_rain != '0);
    assign o_status.div_last = (r_cnt == CNT_LAST);
    assign o_infil_depth     = r_out_infil;
    assign o_capacity_left   = r_out_cap;

endmodule

FILE: sv/curve_number_infiltration_step_core.sv
`timescale 1ns / 1ps

// Curve-number infiltration, one time step per beat. An input beat carries the
// step's rain and ponded depths (unsigned, 24 fraction bits); one output beat
// returns the infiltrated depth and the retention capacity left. A new beat is
// taken only once the step before it has committed. In a rainy step the partial
// products of event rain and event capacity are formed in the mul_lo and mul_hi
// states, then a restoring divider yields one quotient bit per cycle. A step
// without rain skips the products and the divider. A finished result waits in the
// output register, so the next beat is accepted while it is held; the block only
// waits at the end of a step if that register is full and stalled. Configuration is
// taken while no step is in progress; writing smax_depth restarts the event state.
module curve_number_infiltration_step_core #(
    parameter int DEPTH_WIDTH = cnis_pkg::DEPTH_WIDTH_DEF,
    parameter int COUNT_WIDTH = cnis_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [DEPTH_WIDTH-1:0]               i_rain_depth,
    input  logic [DEPTH_WIDTH-1:0]               i_ponded_depth,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [DEPTH_WIDTH-1:0]               o_infil_depth,
    output logic [DEPTH_WIDTH-1:0]               o_capacity_left,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [cnis_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [DEPTH_WIDTH-1:0]               i_cfg_data
);
    import cnis_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_cfg_we;

    assign w_cfg_we = i_cfg_valid && o_cfg_ready;

    // step sequencer
    cnis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cfg_ready (o_cfg_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // arithmetic and state
    cnis_dp #(
        .DEPTH_WIDTH (DEPTH_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_rain_depth    (i_rain_depth),
        .i_ponded_depth  (i_ponded_depth),
        .i_cfg_we        (w_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_infil_depth   (o_infil_depth),
        .o_capacity_left (o_capacity_left)
    );

endmodule

FILE: sv/cnis_checker.sv
`timescale 1ns / 1ps

module cnis_checker #(
    parameter int DEPTH_WIDTH = cnis_pkg::DEPTH_WIDTH_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [DEPTH_WIDTH-1:0] o_infil_depth,
    input logic [DEPTH_WIDTH-1:0] o_capacity_left,
    input logic                   o_cfg_ready
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_infil_depth)
            && $stable(o_capacity_left))
        else $error("result beat changed while stalled");

    // an accepted beat keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block not busy after accepting a beat");

    // configuration is only taken between steps
    a_cfg_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_in_stall)
        else $error("configuration ready during a step");

    // a new result only appears at the end of a step in progress
    a_result_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result beat without a step in progress");

endmodule

bind curve_number_infiltration_step_core cnis_checker #(
    .DEPTH_WIDTH (DEPTH_WIDTH)
) u_cnis_checker (.*);
